FILE: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and the control store of the core allocator sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int unsigned LoadW  = 16;
  localparam int unsigned SumW   = 17;
  localparam int unsigned TaskW  = 8;
  localparam int unsigned PolW   = 2;
  localparam int unsigned CidxW  = 2;
  localparam int unsigned StepW  = 3;

  localparam logic [SumW-1:0] ONE_Q15 = 17'd32768;

  typedef enum logic [PolW-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_ALT   = 2'd3
  } policy_e;

  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_PLACE = 1'b1;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_NO_START,
    BR_CLEAR,
    BR_MORE
  } branch_e;

  localparam logic [StepW-1:0] STEP_IDLE  = 3'd0;
  localparam logic [StepW-1:0] STEP_FIRST = 3'd1;
  localparam logic [StepW-1:0] STEP_SCAN  = 3'd2;
  localparam logic [StepW-1:0] STEP_UPD   = 3'd3;
  localparam logic [StepW-1:0] STEP_CLR   = 3'd4;

  typedef struct packed {
    logic             latch;
    logic             rd;
    logic             ev;
    logic             wr;
    logic             clr;
    logic             emit;
    branch_e          br;
    logic [StepW-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic clear_act;
    logic more;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [StepW-1:0] step);
    ctrl_t cw;
    cw = '{latch: 1'b0, rd: 1'b0, ev: 1'b0, wr: 1'b0, clr: 1'b0, emit: 1'b0,
           br: BR_ALWAYS, tgt: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        cw.latch = 1'b1;
        cw.br    = BR_NO_START;
        cw.tgt   = STEP_IDLE;
      end
      STEP_FIRST: begin
        cw.rd  = 1'b1;
        cw.br  = BR_CLEAR;
        cw.tgt = STEP_CLR;
      end
      STEP_SCAN: begin
        cw.rd  = 1'b1;
        cw.ev  = 1'b1;
        cw.br  = BR_MORE;
        cw.tgt = STEP_SCAN;
      end
      STEP_UPD: begin
        cw.wr   = 1'b1;
        cw.emit = 1'b1;
      end
      STEP_CLR: begin
        cw.clr  = 1'b1;
        cw.emit = 1'b1;
      end
      default: begin
        cw.br  = BR_ALWAYS;
        cw.tgt = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/bpa_seq.sv
// ----------------------------------------------------------------------------
// bpa_seq
// Microcode sequencer: step counter, control store lookup and branch logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_seq
  import bpa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);

  logic [StepW-1:0] step_q, step_d;
  ctrl_t            cw;
  logic             jump;

  always_comb begin
    cw = ucode_rom(step_q);
    unique case (cw.br)
      BR_NEXT:     jump = 1'b0;
      BR_ALWAYS:   jump = 1'b1;
      BR_NO_START: jump = !start_i;
      BR_CLEAR:    jump = stat_i.clear_act;
      BR_MORE:     jump = stat_i.more;
      default:     jump = 1'b1;
    endcase
    step_d = jump ? cw.tgt : step_q + StepW'(1);
    ctrl_o       = cw;
    ctrl_o.latch = cw.latch & start_i;
  end

  assign busy_o = (step_q != STEP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: core load store, fit test and selection, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_dp
  import bpa_pkg::*;
#(
  parameter int unsigned NUM_CORES = 4,
  localparam int unsigned AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1,
  localparam int unsigned CW = $clog2(NUM_CORES + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_t            ctrl_i,
  input  wire logic [PolW-1:0]  policy_i,
  input  wire logic             action_i,
  input  wire logic [TaskW-1:0] task_index_i,
  input  wire logic [LoadW-1:0] task_load_i,
  output stat_t                 stat_o,
  output logic                  result_valid_o,
  output logic                  placed_o,
  output logic [CidxW-1:0]      core_index_o,
  output logic [LoadW-1:0]      core_load_after_o,
  output logic [TaskW-1:0]      task_echo_o
);

  logic                 act_q;
  logic [TaskW-1:0]     task_q;
  logic [LoadW-1:0]     load_q;
  logic [CW-1:0]        cnt_q;
  logic [AW-1:0]        ev_idx_q;
  logic                 found_q;
  logic [AW-1:0]        pick_q;
  logic [LoadW-1:0]     pick_sum_q;
  logic [NUM_CORES-1:0] vld_q;
  logic                 vld_rd_q;
  logic                 strobe_q;
  logic [LoadW-1:0]     rd_data;
  logic [LoadW-1:0]     cur_load;
  logic [SumW-1:0]      sum;
  logic                 fits;
  logic                 take;
  logic [AW-1:0]        raddr;

  assign raddr = cnt_q[AW-1:0];

  bpa_ram #(
    .WIDTH(LoadW),
    .DEPTH(NUM_CORES)
  ) u_load_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr & found_q),
    .waddr_i(pick_q),
    .wdata_i(pick_sum_q),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  always_comb begin
    cur_load = vld_rd_q ? rd_data : '0;
    sum      = {1'b0, cur_load} + {1'b0, load_q};
    fits     = (sum <= ONE_Q15);
    case (policy_e'(policy_i))
      POL_BEST:  take = fits && (!found_q || (sum > {1'b0, pick_sum_q}));
      POL_WORST: take = fits && (!found_q || (sum < {1'b0, pick_sum_q}));
      default:   take = fits && !found_q;
    endcase
  end

  assign stat_o.clear_act = (act_q == ACT_CLEAR);
  assign stat_o.more      = (cnt_q != CW'(NUM_CORES));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      act_q  <= action_i;
      task_q <= task_index_i;
      load_q <= task_load_i;
    end
    if (ctrl_i.rd) begin
      vld_rd_q <= vld_q[raddr];
    end
    if (ctrl_i.ev && take) begin
      pick_q     <= ev_idx_q;
      pick_sum_q <= sum[LoadW-1:0];
    end
    if (ctrl_i.emit) begin
      placed_o          <= found_q;
      core_index_o      <= found_q ? CidxW'(pick_q) : '0;
      core_load_after_o <= found_q ? pick_sum_q : '0;
      task_echo_o       <= task_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ev_idx_q <= '0;
      found_q  <= 1'b0;
      vld_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ctrl_i.emit;
      if (ctrl_i.latch) begin
        cnt_q    <= '0;
        ev_idx_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (ctrl_i.rd) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (ctrl_i.ev) begin
          ev_idx_q <= ev_idx_q + AW'(1);
          if (take) begin
            found_q <= 1'b1;
          end
        end
      end
      if (ctrl_i.clr) begin
        vld_q <= '0;
      end else if (ctrl_i.wr && found_q) begin
        vld_q[pick_q] <= 1'b1;
      end
    end
  end

  assign result_valid_o = strobe_q;

endmodule

`default_nettype wire

FILE: rtl/core/bin_packing_core_allocator_core.sv
// ----------------------------------------------------------------------------
// bin_packing_core_allocator_core
// Places tasks onto cores by utilization with first, best or worst fit, or clears all cores.
//
// Channel   Direction  Handshake                 Beat
// command   in         start / busy              action, task_index, task_load
// result    out        result_valid (strobe)     placed, core_index,
//                                                core_load_after, task_echo
// config    in         cfg_we (no wait)          fit_policy
//
// A place beat runs a first RAM read, one scan step per core and an update
// step, then raises the result strobe. A clear beat runs the first read and a
// clear step, then raises the strobe. Busy falls as the strobe rises, so a new
// beat is accepted only once the previous result is out. The receiver cannot
// stall; each result is shown for one cycle.
// Reset marks every core load as zero and selects first fit.
// ----------------------------------------------------------------------------
`default_nettype none

module bin_packing_core_allocator_core
  import bpa_pkg::*;
#(
  parameter int unsigned NUM_CORES = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             action_i,
  input  wire logic [TaskW-1:0] task_index_i,
  input  wire logic [LoadW-1:0] task_load_i,
  input  wire logic             cfg_we_i,
  input  wire logic [PolW-1:0]  cfg_wdata_i,
  output logic                  result_valid_o,
  output logic                  placed_o,
  output logic [CidxW-1:0]      core_index_o,
  output logic [LoadW-1:0]      core_load_after_o,
  output logic [TaskW-1:0]      task_echo_o
);

  logic [PolW-1:0] policy_q;
  ctrl_t           ctrl;
  stat_t           stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  bpa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  bpa_dp #(
    .NUM_CORES(NUM_CORES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .policy_i         (policy_q),
    .action_i         (action_i),
    .task_index_i     (task_index_i),
    .task_load_i      (task_load_i),
    .stat_o           (stat),
    .result_valid_o   (result_valid_o),
    .placed_o         (placed_o),
    .core_index_o     (core_index_o),
    .core_load_after_o(core_load_after_o),
    .task_echo_o      (task_echo_o)
  );

endmodule

`default_nettype wire

FILE: tb/bin_packing_core_allocator_core_test.sv
// ----------------------------------------------------------------------------
// bin_packing_core_allocator_core_test
// Drives place and clear commands into the core allocator under every fit
// policy. Each command beat is run through a software copy of the core loads,
// and the result is compared with the prediction field by field. The sender
// works in random bursts, and the policy changes only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bin_packing_core_allocator_core_test
  import bpa_pkg::*;
();

  localparam int unsigned NUM_CORES      = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 92;

  typedef struct {
    logic             action;
    logic [TaskW-1:0] task_id;
    logic [LoadW-1:0] load;
  } command_t;

  typedef struct {
    logic             placed;
    logic [CidxW-1:0] core;
    logic [LoadW-1:0] load_after;
    logic [TaskW-1:0] echo;
  } placement_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             action = ACT_CLEAR;
  logic [TaskW-1:0] task_id = '0;
  logic [LoadW-1:0] task_load = '0;
  logic             cfg_we = 1'b0;
  logic [PolW-1:0]  cfg_wdata = '0;
  logic             result_valid;
  logic             placed;
  logic [CidxW-1:0] core_index;
  logic [LoadW-1:0] core_load_after;
  logic [TaskW-1:0] task_echo;

  command_t   cmd_backlog[$];
  placement_t due_placements[$];
  command_t   in_flight;
  logic [LoadW-1:0] shadow_load[NUM_CORES];
  policy_e    shadow_policy = POL_FIRST;
  int unsigned gap_left = 0;
  int unsigned burst_left = 8;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;

  bin_packing_core_allocator_core #(
    .NUM_CORES(NUM_CORES)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .action_i         (action),
    .task_index_i     (task_id),
    .task_load_i      (task_load),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .result_valid_o   (result_valid),
    .placed_o         (placed),
    .core_index_o     (core_index),
    .core_load_after_o(core_load_after),
    .task_echo_o      (task_echo)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic placement_t allocate_task(command_t c);
    placement_t       r;
    logic [SumW-1:0]  sum;
    logic [SumW-1:0]  pick_sum;
    logic             hit;
    logic             take;
    int unsigned      pick;
    r = '{placed: 1'b0, core: '0, load_after: '0, echo: c.task_id};
    hit = 1'b0;
    pick = 0;
    pick_sum = '0;
    if (c.action == ACT_PLACE) begin
      for (int k = 0; k < NUM_CORES; k++) begin
        sum = {1'b0, shadow_load[k]} + {1'b0, c.load};
        if (sum <= ONE_Q15) begin
          if (!hit) begin
            take = 1'b1;
          end else if (shadow_policy == POL_BEST) begin
            take = sum > pick_sum;
          end else if (shadow_policy == POL_WORST) begin
            take = sum < pick_sum;
          end else begin
            take = 1'b0;
          end
          if (take) begin
            hit = 1'b1;
            pick = k;
            pick_sum = sum;
          end
        end
      end
      if (hit) begin
        shadow_load[pick] = pick_sum[LoadW-1:0];
        r.placed = 1'b1;
        r.core = pick[CidxW-1:0];
        r.load_after = pick_sum[LoadW-1:0];
      end
    end else begin
      for (int k = 0; k < NUM_CORES; k++) shadow_load[k] = '0;
    end
    return r;
  endfunction

  function automatic command_t random_command();
    command_t    c;
    int unsigned roll;
    logic [LoadW-1:0] corners[8];
    corners = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd32769, 16'hFFFF, 16'd16384,
                16'd8192};
    c.task_id = TaskW'($urandom_range(0, 255));
    c.action = ACT_PLACE;
    c.load = LoadW'($urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      c.action = ACT_CLEAR;
    end else if (roll < 60) begin
      c.load = LoadW'($urandom_range(0, 12000));
    end else if (roll < 78) begin
      c.load = LoadW'($urandom_range(0, 32768));
    end else if (roll < 92) begin
      c.load = corners[$urandom_range(0, 7)];
    end
    return c;
  endfunction

  task automatic queue_command(logic act, logic [TaskW-1:0] id, logic [LoadW-1:0] load);
    command_t c;
    c = '{action: act, task_id: id, load: load};
    cmd_backlog.push_back(c);
  endtask

  // The block counts as idle only once the calm count of edges with nothing
  // pending reaches its limit, so a command taken from the backlog at the same edge is never missed.
  task automatic wait_idle();
    int unsigned calm;
    calm = 0;
    while (calm < 2) begin
      @(posedge clk);
      if (cmd_backlog.size() == 0 && !start && due_placements.size() == 0 && !busy) begin
        calm++;
      end else begin
        calm = 0;
      end
    end
  endtask

  task automatic write_policy(policy_e pol);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_policy = pol;
    @(posedge clk);
  endtask

  task automatic report(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_placements.push_back(allocate_task(in_flight));
      end
      if (!start || !busy) begin
        if (gap_left == 0 && cmd_backlog.size() != 0) begin
          in_flight = cmd_backlog.pop_front();
          start <= 1'b1;
          action <= in_flight.action;
          task_id <= in_flight.task_id;
          task_load <= in_flight.load;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && result_valid) begin
      if (due_placements.size() == 0) begin
        $display("%0t: result beat with no placement outstanding, task_echo actual %0d",
                 $time, task_echo);
        mismatches++;
      end else begin
        want = due_placements.pop_front();
        report("placed", want.placed, placed);
        report("core_index", want.core, core_index);
        report("core_load_after", want.load_after, core_load_after);
        report("task_echo", want.echo, task_echo);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    policy_e pol;
    for (int k = 0; k < NUM_CORES; k++) shadow_load[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_policy(POL_FIRST);
    queue_command(ACT_CLEAR, 8'd0, 16'd0);
    queue_command(ACT_PLACE, 8'd255, 16'd0);
    queue_command(ACT_PLACE, 8'd1, 16'd32768);
    queue_command(ACT_PLACE, 8'd2, 16'd32768);
    queue_command(ACT_PLACE, 8'd3, 16'd16384);
    queue_command(ACT_PLACE, 8'd4, 16'd16384);
    queue_command(ACT_PLACE, 8'd5, 16'd32769);
    queue_command(ACT_PLACE, 8'd6, 16'hFFFF);
    queue_command(ACT_PLACE, 8'd7, 16'd1);
    queue_command(ACT_PLACE, 8'd8, 16'd32767);
    queue_command(ACT_PLACE, 8'd9, 16'd1);
    queue_command(ACT_PLACE, 8'd10, 16'd0);
    queue_command(ACT_CLEAR, 8'hAA, 16'hFFFF);
    for (int p = 0; p < 2; p++) begin
      write_policy(p == 0 ? POL_BEST : POL_WORST);
      queue_command(ACT_PLACE, 8'h55, 16'd8000);
      queue_command(ACT_PLACE, 8'h56, 16'd16000);
      queue_command(ACT_PLACE, 8'h57, 16'd24000);
      queue_command(ACT_PLACE, 8'h58, 16'd8768);
      queue_command(ACT_CLEAR, 8'h59, 16'd0);
    end

    for (int ph = 0; ph < 8; ph++) begin
      pol = (ph < 4) ? policy_e'(ph) : policy_e'($urandom_range(0, 3));
      write_policy(pol);
      for (int n = 0; n < PHASE_ITEMS; n++) cmd_backlog.push_back(random_command());
    end

    wait_idle();
    repeat (NUM_CORES + 8) @(posedge clk);
    if (mismatches == 0 && due_placements.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_seq.sv
rtl/core/bpa_dp.sv
rtl/core/bin_packing_core_allocator_core.sv
tb/bin_packing_core_allocator_core_test.sv
